// ===== sv/tkd_pkg.sv =====
// Shared types, constants and register codes for the TIFF key tag detector.
`timescale 1ns / 1ps
package tkd_pkg;

  // Width of the saturating byte position counter
  localparam int unsigned OFFSET_BITS = 32;
  localparam logic [63:0] POS_LIMIT = 64'({OFFSET_BITS{1'b1}});

  localparam logic [31:0] RESET_MAX_DIR_OFFSET = 32'd104857600;
  localparam logic [15:0] RESET_MAX_ENTRIES    = 16'd4096;
  localparam logic [15:0] RESET_KEY_TAG        = 16'd34735;

  localparam logic [7:0]  MARK_LITTLE     = 8'h49;
  localparam logic [7:0]  MARK_BIG        = 8'h4D;
  localparam logic [63:0] VERSION_CLASSIC = 64'd42;
  localparam logic [63:0] VERSION_BIG     = 64'd43;

  localparam logic [4:0] ENTRY_BYTES_CLASSIC = 5'd12;
  localparam logic [4:0] ENTRY_BYTES_BIG     = 5'd20;
  localparam logic [4:0] COUNT_BYTES_CLASSIC = 5'd2;
  localparam logic [4:0] COUNT_BYTES_BIG     = 5'd8;

  typedef enum logic [1:0] {
    CFG_MAX_DIR_OFFSET = 2'd0,
    CFG_MAX_ENTRIES    = 2'd1,
    CFG_KEY_TAG        = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    VERDICT_FOUND    = 2'd0,
    VERDICT_NO_TAG   = 2'd1,
    VERDICT_NOT_TIFF = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [31:0] max_dir_offset;
    logic [15:0] max_entries;
    logic [15:0] key_tag;
  } tkd_cfg_t;

  typedef struct packed {
    verdict_e    verdict;
    logic        little_endian;
    logic        big_tiff;
    logic [31:0] dir_offset;
  } tkd_result_t;

endpackage

// ===== sv/tkd_cfg_regs.sv =====
// Configuration register file: directory offset limit, entry limit, key tag.
`timescale 1ns / 1ps
module tkd_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [1:0]        wr_index_i,
  input  logic [31:0]       wr_data_i,
  output tkd_pkg::tkd_cfg_t cfg_o
);
  import tkd_pkg::*;

  tkd_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        CFG_MAX_DIR_OFFSET: cfg_d.max_dir_offset = wr_data_i;
        CFG_MAX_ENTRIES:    cfg_d.max_entries    = wr_data_i[15:0];
        CFG_KEY_TAG:        cfg_d.key_tag        = wr_data_i[15:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_dir_offset <= RESET_MAX_DIR_OFFSET;
      cfg_q.max_entries    <= RESET_MAX_ENTRIES;
      cfg_q.key_tag        <= RESET_KEY_TAG;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/tkd_parser.sv =====
// Per-byte header, directory and entry parser with its file state.
`timescale 1ns / 1ps
module tkd_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 file_end_i,
  input  tkd_pkg::tkd_cfg_t    cfg_i,
  output logic                 res_valid_o,
  output tkd_pkg::tkd_result_t res_o
);
  import tkd_pkg::*;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_SKIP    = 5'b00010,
    PH_COUNT   = 5'b00100,
    PH_ENTRIES = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_e;

  typedef logic [OFFSET_BITS-1:0] pos_t;

  phase_e      phase_q, phase_d;
  pos_t        pos_q, pos_d;
  logic        little_q, little_d;
  logic        big_q, big_d;
  logic [63:0] gather_q, gather_d;
  logic [31:0] dir_off_q, dir_off_d;
  logic [15:0] left_q, left_d;
  logic [4:0]  idx_q, idx_d;
  logic        given_q, given_d;

  logic [63:0] word;
  logic [63:0] lim;
  logic [63:0] next_pos;
  pos_t        first_pos;
  pos_t        last_pos;
  logic [2:0]  first_lane;
  logic [4:0]  idx_inc;
  logic [15:0] left_dec;
  logic        fin;
  verdict_e    verd;

  // Little endian fills byte lanes upwards, big endian shifts in at the bottom
  function automatic logic [63:0] take_byte(input logic [63:0] w, input logic [2:0] k,
                                            input logic [7:0] b, input logic little);
    logic [63:0] r;
    if (little) r = w | ({56'd0, b} << {k, 3'b000});
    else        r = {w[55:0], b};
    return r;
  endfunction

  assign lim = (64'(cfg_i.max_dir_offset) > POS_LIMIT) ? POS_LIMIT
                                                        : 64'(cfg_i.max_dir_offset);
  assign first_pos  = big_q ? pos_t'(8) : pos_t'(4);
  assign last_pos   = big_q ? pos_t'(15) : pos_t'(7);
  assign first_lane = big_q ? 3'd0 : 3'd4;
  assign next_pos   = big_q ? 64'd16 : 64'd8;
  assign idx_inc    = idx_q + 5'd1;
  assign left_dec   = (left_q != 16'd0) ? left_q - 16'd1 : 16'd0;

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    little_d  = little_q;
    big_d     = big_q;
    gather_d  = gather_q;
    dir_off_d = dir_off_q;
    left_d    = left_q;
    idx_d     = idx_q;
    given_d   = given_q;
    word      = '0;
    fin       = 1'b0;
    verd      = VERDICT_NOT_TIFF;

    unique case (phase_q)
      PH_HEADER: begin
        if (pos_q == pos_t'(0)) begin
          gather_d = {56'd0, data_byte_i};
        end else if (pos_q == pos_t'(1)) begin
          if (gather_q == 64'(MARK_LITTLE) && data_byte_i == MARK_LITTLE) begin
            little_d = 1'b1;
          end else if (gather_q == 64'(MARK_BIG) && data_byte_i == MARK_BIG) begin
            little_d = 1'b0;
          end else begin
            fin  = 1'b1;
            verd = VERDICT_NOT_TIFF;
          end
          gather_d = '0;
        end else if (pos_q <= pos_t'(3)) begin
          word     = take_byte(gather_q, pos_q[2:0] - 3'd2, data_byte_i, little_q);
          gather_d = word;
          if (pos_q == pos_t'(3)) begin
            if (word == VERSION_CLASSIC) begin
              big_d = 1'b0;
            end else if (word == VERSION_BIG) begin
              big_d = 1'b1;
            end else begin
              fin  = 1'b1;
              verd = VERDICT_NOT_TIFF;
            end
            gather_d = '0;
          end
        end else if (pos_q >= first_pos) begin
          word     = take_byte(gather_q, pos_q[2:0] - first_lane, data_byte_i, little_q);
          gather_d = word;
          if (pos_q == last_pos) begin
            dir_off_d = (word[63:32] != 32'd0) ? 32'hFFFF_FFFF : word[31:0];
            if (word < next_pos || word > lim) begin
              fin  = 1'b1;
              verd = VERDICT_NOT_TIFF;
            end else begin
              gather_d = '0;
              idx_d    = '0;
              phase_d  = (word == next_pos) ? PH_COUNT : PH_SKIP;
            end
          end
        end
      end
      PH_SKIP: begin
        if (65'(pos_q) + 65'd1 == 65'(dir_off_q)) begin
          phase_d  = PH_COUNT;
          gather_d = '0;
          idx_d    = '0;
        end
      end
      PH_COUNT: begin
        word     = take_byte(gather_q, idx_q[2:0], data_byte_i, little_q);
        gather_d = word;
        idx_d    = idx_inc;
        if (idx_inc == (big_q ? COUNT_BYTES_BIG : COUNT_BYTES_CLASSIC)) begin
          if (word > 64'(cfg_i.max_entries)) begin
            fin  = 1'b1;
            verd = VERDICT_NOT_TIFF;
          end else if (word == 64'd0) begin
            fin  = 1'b1;
            verd = VERDICT_NO_TAG;
          end else begin
            left_d   = word[15:0];
            phase_d  = PH_ENTRIES;
            idx_d    = '0;
            gather_d = '0;
          end
        end
      end
      PH_ENTRIES: begin
        word = gather_q;
        if (idx_q < 5'd2) begin
          word = take_byte(gather_q, idx_q[2:0], data_byte_i, little_q);
        end
        gather_d = word;
        if (idx_inc >= (big_q ? ENTRY_BYTES_BIG : ENTRY_BYTES_CLASSIC)) begin
          if (word == 64'(cfg_i.key_tag)) begin
            fin  = 1'b1;
            verd = VERDICT_FOUND;
          end else begin
            left_d = left_dec;
            if (left_dec == 16'd0) begin
              fin  = 1'b1;
              verd = VERDICT_NO_TAG;
            end else begin
              idx_d    = '0;
              gather_d = '0;
            end
          end
        end else begin
          idx_d = idx_inc;
        end
      end
      PH_DONE: begin
        phase_d = PH_DONE;
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase

    if (fin) begin
      given_d = 1'b1;
      phase_d = PH_DONE;
    end

    if (pos_q != pos_t'(POS_LIMIT)) pos_d = pos_q + pos_t'(1);

    // Truncated file: a verdict is forced on the last byte
    if (file_end_i && !given_d) begin
      fin  = 1'b1;
      verd = VERDICT_NOT_TIFF;
    end

    res_o.verdict       = verd;
    res_o.little_endian = little_d;
    res_o.big_tiff      = big_d;
    res_o.dir_offset    = dir_off_d;

    if (file_end_i) begin
      phase_d   = PH_HEADER;
      pos_d     = '0;
      little_d  = 1'b0;
      big_d     = 1'b0;
      gather_d  = '0;
      dir_off_d = '0;
      left_d    = '0;
      idx_d     = '0;
      given_d   = 1'b0;
    end
  end

  assign res_valid_o = fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      pos_q     <= '0;
      little_q  <= 1'b0;
      big_q     <= 1'b0;
      gather_q  <= '0;
      dir_off_q <= '0;
      left_q    <= '0;
      idx_q     <= '0;
      given_q   <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      little_q  <= little_d;
      big_q     <= big_d;
      gather_q  <= gather_d;
      dir_off_q <= dir_off_d;
      left_q    <= left_d;
      idx_q     <= idx_d;
      given_q   <= given_d;
    end
  end

endmodule

// ===== sv/tiff_key_tag_detector.sv =====
// Top level: input register, parser, configuration registers, result register.
// Verdict path: input register, parser step, result register, then the outputs.
// Throughput: one byte per cycle; a held result stalls only a byte that brings a verdict,
//   and the single parser step between the two registers sets this rate.
// Reset: asynchronous, active low; parser back in the header phase, default limits
//   and key tag. Configuration is always ready.
`timescale 1ns / 1ps
module tiff_key_tag_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        file_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  verdict_o,
  output logic        little_endian_o,
  output logic        big_tiff_o,
  output logic [31:0] dir_offset_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import tkd_pkg::*;

  logic        in_v_q, in_v_d;
  logic [7:0]  byte_q;
  logic        end_q;
  logic        out_v_q, out_v_d;
  tkd_result_t out_q;
  tkd_result_t res;
  logic        res_valid;
  logic        step;
  tkd_cfg_t    cfg;

  assign cfg_ready_o = 1'b1;

  tkd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Held byte advances unless its verdict would meet a result register still held
  assign step       = in_v_q && (!out_v_q || out_ready_i || !res_valid);
  assign in_ready_o = !in_v_q || step;

  tkd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (byte_q),
    .file_end_i  (end_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    in_v_d = in_v_q;
    if (in_valid_i && in_ready_o) in_v_d = 1'b1;
    else if (step)                in_v_d = 1'b0;

    out_v_d = out_v_q;
    if (step && res_valid) out_v_d = 1'b1;
    else if (out_ready_i)  out_v_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
      end_q  <= file_end_i;
    end
    if (step && res_valid) out_q <= res;
  end

  assign out_valid_o     = out_v_q;
  assign verdict_o       = out_q.verdict;
  assign little_endian_o = out_q.little_endian;
  assign big_tiff_o      = out_q.big_tiff;
  assign dir_offset_o    = out_q.dir_offset;

endmodule

// ===== verif/tiff_key_tag_detector_tb.sv =====
// Self-checking testbench for the TIFF key tag detector: file streams in, verdicts checked.
`timescale 1ns / 1ps
module tiff_key_tag_detector_tb;
  import tkd_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_SKIP,
    ST_COUNT,
    ST_ENTRIES,
    ST_DONE
  } scan_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } file_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        file_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  verdict_o;
  logic        little_endian_o;
  logic        big_tiff_o;
  logic [31:0] dir_offset_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  // Mirror of the register file and of the parser state
  tkd_cfg_t    limits = '{RESET_MAX_DIR_OFFSET, RESET_MAX_ENTRIES, RESET_KEY_TAG};
  scan_phase_e sc_phase = ST_HEADER;
  logic [63:0] sc_pos = '0;
  logic        sc_little = 1'b0;
  logic        sc_big = 1'b0;
  logic [63:0] sc_word = '0;
  logic [31:0] sc_dir_off = '0;
  logic [15:0] sc_left = '0;
  logic [4:0]  sc_idx = '0;
  logic        sc_done = 1'b0;

  tkd_result_t pending_verdicts[$];
  tkd_result_t want;
  file_item_t  file_stream[$];
  logic [7:0]  file_bytes[$];

  int  errors = 0;
  int  queued_bytes = 0;
  int  quiet_cycles = 0;
  int  hold_len = 0;
  bit  calm = 1'b0;

  tiff_key_tag_detector dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .file_end_i     (file_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .verdict_o      (verdict_o),
    .little_endian_o(little_endian_o),
    .big_tiff_o     (big_tiff_o),
    .dir_offset_o   (dir_offset_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- prediction

  function automatic logic [63:0] gather(input logic [63:0] w, input logic [4:0] k,
                                         input logic [7:0] b, input logic le);
    if (le) return w | ({56'd0, b} << (8 * k[2:0]));
    return {w[55:0], b};
  endfunction

  function automatic void clear_scan();
    sc_phase   = ST_HEADER;
    sc_pos     = '0;
    sc_little  = 1'b0;
    sc_big     = 1'b0;
    sc_word    = '0;
    sc_dir_off = '0;
    sc_left    = '0;
    sc_idx     = '0;
    sc_done    = 1'b0;
  endfunction

  function automatic void conclude(input verdict_e v);
    tkd_result_t r;
    r.verdict       = v;
    r.little_endian = sc_little;
    r.big_tiff      = sc_big;
    r.dir_offset    = sc_dir_off;
    pending_verdicts.push_back(r);
    sc_done  = 1'b1;
    sc_phase = ST_DONE;
  endfunction

  function automatic void check_offset(input logic [63:0] next);
    logic [63:0] lim;
    sc_dir_off = (sc_word > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sc_word[31:0];
    lim = {32'd0, limits.max_dir_offset};
    if (lim > POS_LIMIT) lim = POS_LIMIT;
    if (sc_word < next || sc_word > lim) begin
      conclude(VERDICT_NOT_TIFF);
    end else begin
      sc_phase = (sc_word == next) ? ST_COUNT : ST_SKIP;
      sc_word  = '0;
      sc_idx   = '0;
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic fin);
    logic [63:0] p;
    logic [63:0] first;
    logic [63:0] last;
    logic [4:0]  size;
    p = sc_pos;
    case (sc_phase)
      ST_HEADER: begin
        if (p == 0) begin
          sc_word = {56'd0, b};
        end else if (p == 1) begin
          if (sc_word == {56'd0, MARK_LITTLE} && b == MARK_LITTLE) sc_little = 1'b1;
          else if (sc_word == {56'd0, MARK_BIG} && b == MARK_BIG) sc_little = 1'b0;
          else conclude(VERDICT_NOT_TIFF);
          sc_word = '0;
        end else if (p <= 3) begin
          sc_word = gather(sc_word, 5'(p - 2), b, sc_little);
          if (p == 3) begin
            if (sc_word == VERSION_CLASSIC) sc_big = 1'b0;
            else if (sc_word == VERSION_BIG) sc_big = 1'b1;
            else conclude(VERDICT_NOT_TIFF);
            sc_word = '0;
          end
        end else begin
          // BigTIFF keeps bytes 4..7 out of the offset
          first = sc_big ? 64'd8 : 64'd4;
          last  = sc_big ? 64'd15 : 64'd7;
          if (p >= first) begin
            sc_word = gather(sc_word, 5'(p - first), b, sc_little);
            if (p == last) check_offset(p + 1);
          end
        end
      end
      ST_SKIP: begin
        if (p + 1 == {32'd0, sc_dir_off}) begin
          sc_phase = ST_COUNT;
          sc_word  = '0;
          sc_idx   = '0;
        end
      end
      ST_COUNT: begin
        sc_word = gather(sc_word, sc_idx, b, sc_little);
        sc_idx  = sc_idx + 5'd1;
        if (sc_idx == (sc_big ? COUNT_BYTES_BIG : COUNT_BYTES_CLASSIC)) begin
          if (sc_word > {48'd0, limits.max_entries}) begin
            conclude(VERDICT_NOT_TIFF);
          end else if (sc_word == 0) begin
            conclude(VERDICT_NO_TAG);
          end else begin
            sc_left  = sc_word[15:0];
            sc_phase = ST_ENTRIES;
            sc_idx   = '0;
            sc_word  = '0;
          end
        end
      end
      ST_ENTRIES: begin
        size = sc_big ? ENTRY_BYTES_BIG : ENTRY_BYTES_CLASSIC;
        if (sc_idx < 2) sc_word = gather(sc_word, sc_idx, b, sc_little);
        if (sc_idx + 5'd1 >= size) begin
          // tag decision waits for the entry's last byte
          if (sc_word == {48'd0, limits.key_tag}) begin
            conclude(VERDICT_FOUND);
          end else begin
            if (sc_left != 0) sc_left = sc_left - 16'd1;
            if (sc_left == 0) begin
              conclude(VERDICT_NO_TAG);
            end else begin
              sc_idx  = '0;
              sc_word = '0;
            end
          end
        end else begin
          sc_idx = sc_idx + 5'd1;
        end
      end
      default: ;
    endcase
    if (sc_pos < POS_LIMIT) sc_pos = sc_pos + 64'd1;
    if (fin) begin
      if (!sc_done) conclude(VERDICT_NOT_TIFF);
      clear_scan();
    end
  endfunction

  // ---------------------------------------------------------------- driver, monitor, watchdog

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) parse_byte(data_byte_i, file_end_i);
      if (!in_valid_i || in_ready_o) begin
        if (file_stream.size() != 0 && (calm || $urandom_range(99) >= 35)) begin
          in_valid_i  <= 1'b1;
          data_byte_i <= file_stream[0].data;
          file_end_i  <= file_stream[0].fin;
          void'(file_stream.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_verdicts.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: verdict %0d offset %0d",
                   $time, verdict_o, dir_offset_o);
        end else begin
          want = pending_verdicts.pop_front();
          if (verdict_o !== want.verdict) begin
            errors++;
            $display("%0t: verdict expected %0d, got %0d", $time, want.verdict, verdict_o);
          end
          if (little_endian_o !== want.little_endian) begin
            errors++;
            $display("%0t: little_endian expected %0d, got %0d",
                     $time, want.little_endian, little_endian_o);
          end
          if (big_tiff_o !== want.big_tiff) begin
            errors++;
            $display("%0t: big_tiff expected %0d, got %0d", $time, want.big_tiff, big_tiff_o);
          end
          if (dir_offset_o !== want.dir_offset) begin
            errors++;
            $display("%0t: dir_offset expected %0h, got %0h",
                     $time, want.dir_offset, dir_offset_o);
          end
        end
      end
      if (hold_len > 0) begin
        hold_len--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 35);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  task automatic put_word(input logic [63:0] v, input int nbytes, input bit le);
    for (int i = 0; i < nbytes; i++)
      file_bytes.push_back(le ? v[8*i +: 8] : v[8*(nbytes-1-i) +: 8]);
  endtask

  task automatic build_tiff(input bit le, input bit bt, input logic [63:0] off,
                            input logic [63:0] cnt, input int n_ent, input int hit);
    logic [15:0] tag;
    file_bytes.delete();
    file_bytes.push_back(le ? MARK_LITTLE : MARK_BIG);
    file_bytes.push_back(le ? MARK_LITTLE : MARK_BIG);
    put_word(bt ? VERSION_BIG : VERSION_CLASSIC, 2, le);
    if (bt) begin
      repeat (4) file_bytes.push_back(8'($urandom));
      put_word(off, 8, le);
    end else begin
      put_word(off, 4, le);
    end
    while (file_bytes.size() < off && file_bytes.size() < 80)
      file_bytes.push_back(8'($urandom));
    put_word(cnt, bt ? 8 : 2, le);
    for (int i = 0; i < n_ent; i++) begin
      tag = 16'($urandom);
      if (i == hit) tag = limits.key_tag;
      else if (tag == limits.key_tag) tag = ~tag;
      put_word({48'd0, tag}, 2, le);
      repeat ((bt ? 20 : 12) - 2) file_bytes.push_back(8'($urandom));
    end
  endtask

  // len <= 0 keeps the built length; otherwise truncate or pad with junk
  task automatic post_file(input int len);
    file_item_t it;
    if (len <= 0) len = file_bytes.size();
    for (int i = 0; i < len; i++) begin
      it.data = (i < file_bytes.size()) ? file_bytes[i] : 8'($urandom);
      it.fin  = (i == len - 1);
      file_stream.push_back(it);
    end
    queued_bytes += len;
  endtask

  task automatic queue_random_file();
    int          kind;
    int          hdr;
    int          n_ent;
    int          hit;
    int          len;
    bit          le;
    bit          bt;
    logic [63:0] off;
    logic [63:0] cnt;
    le    = 1'($urandom_range(1));
    bt    = ($urandom_range(3) == 0);
    hdr   = bt ? 16 : 8;
    off   = hdr + $urandom_range(12);
    n_ent = $urandom_range(1, 4);
    cnt   = n_ent;
    hit   = $urandom_range(1) ? int'($urandom_range(n_ent - 1)) : -1;
    len   = 0;
    kind  = $urandom_range(99);
    if (kind < 10) begin
      cnt = 0;
    end else if (kind < 18) begin
      cnt = bt ? {$urandom, $urandom} : 64'(limits.max_entries) + 1 + $urandom_range(3);
    end else if (kind < 26) begin
      if ($urandom_range(1)) off = $urandom_range(hdr - 1);
      else off = bt ? {$urandom, $urandom} : 64'($urandom);
    end
    build_tiff(le, bt, off, cnt, n_ent, hit);
    if (kind >= 26 && kind < 33) begin
      // broken mark or version
      file_bytes[$urandom_range(3)] = 8'($urandom);
    end else if (kind >= 33 && kind < 40) begin
      len = $urandom_range(1, file_bytes.size() - 1);
    end else if (kind >= 40 && kind < 45) begin
      file_bytes.delete();
      if ($urandom_range(1)) begin
        file_bytes.push_back(le ? MARK_LITTLE : MARK_BIG);
        file_bytes.push_back(le ? MARK_LITTLE : MARK_BIG);
      end
      repeat ($urandom_range(1, 18)) file_bytes.push_back(8'($urandom));
    end else if ($urandom_range(3) == 0) begin
      len = file_bytes.size() + $urandom_range(1, 6);
    end
    post_file(len);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_MAX_DIR_OFFSET: limits.max_dir_offset = val;
      CFG_MAX_ENTRIES:    limits.max_entries = val[15:0];
      default:            limits.key_tag = val[15:0];
    endcase
  endtask

  task automatic shuffle_limits();
    logic [31:0] off_lim;
    logic [15:0] ent_lim;
    case ($urandom_range(3))
      0:       off_lim = $urandom_range(32'hFFFF_FFFF, 8);
      1:       off_lim = $urandom_range(24, 8);
      default: off_lim = $urandom_range(64, 8);
    endcase
    ent_lim = $urandom_range(1) ? 16'($urandom_range(5)) : 16'($urandom);
    write_reg(CFG_MAX_DIR_OFFSET, off_lim);
    write_reg(CFG_MAX_ENTRIES, {16'($urandom), ent_lim});
    write_reg(CFG_KEY_TAG, $urandom);
  endtask

  // Nothing in flight, then a wait for the two register stages to empty
  task automatic drain();
    while (file_stream.size() != 0 || in_valid_i || pending_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    int phase_no;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed files at reset limits
    file_bytes.delete();
    file_bytes.push_back(MARK_LITTLE);
    post_file(0);
    build_tiff(1, 0, 8, 1, 1, 0);
    file_bytes[1] = MARK_BIG;
    post_file(file_bytes.size() + 3);
    build_tiff(1, 0, 8, 1, 1, 0);
    file_bytes[2] = 8'd44;
    post_file(0);
    build_tiff(1, 0, 8, 1, 1, 0);
    post_file(0);
    build_tiff(0, 0, 13, 3, 3, 2);
    post_file(0);
    build_tiff(1, 0, 10, 2, 2, -1);
    post_file(0);
    build_tiff(0, 0, 8, 0, 0, -1);
    post_file(0);
    build_tiff(1, 0, 8, 4097, 1, 0);
    post_file(0);
    build_tiff(1, 0, 7, 1, 1, 0);
    post_file(0);
    build_tiff(0, 0, 64'hFFFF_FFFF, 1, 1, 0);
    post_file(0);
    build_tiff(1, 1, 16, 2, 2, 1);
    post_file(0);
    build_tiff(0, 1, 20, 2, 2, -1);
    post_file(0);
    build_tiff(1, 1, 64'h1_0000_0010, 1, 1, 0);
    post_file(0);
    build_tiff(1, 0, 8, 1, 1, 0);
    post_file(file_bytes.size() - 1);
    build_tiff(0, 0, 8, 2, 2, -1);
    post_file(file_bytes.size() + 5);
    drain();

    // Lowest limits
    write_reg(CFG_MAX_DIR_OFFSET, 32'd8);
    write_reg(CFG_MAX_ENTRIES, 32'hABCD_0000);
    write_reg(CFG_KEY_TAG, 32'h5A5A_0000);
    build_tiff(1, 0, 8, 0, 0, -1);
    post_file(0);
    build_tiff(0, 0, 8, 1, 1, 0);
    post_file(0);
    build_tiff(1, 1, 16, 0, 0, -1);
    post_file(0);
    repeat (4) queue_random_file();
    drain();

    // Highest limits
    write_reg(CFG_MAX_DIR_OFFSET, 32'hFFFF_FFFF);
    write_reg(CFG_MAX_ENTRIES, 32'hFFFF_FFFF);
    write_reg(CFG_KEY_TAG, 32'hFFFF_FFFF);
    build_tiff(0, 0, 8, 65535, 2, 1);
    post_file(0);
    build_tiff(1, 1, 16, 64'h1_0000_0000, 1, 0);
    post_file(0);
    build_tiff(1, 0, 9, 3, 3, -1);
    post_file(0);
    repeat (4) queue_random_file();
    drain();

    phase_no = 0;
    while (queued_bytes < 1450 || phase_no < 2) begin
      shuffle_limits();
      calm = (phase_no == 1);
      if (phase_no == 0) begin
        // results back up behind a stalled receiver
        hold_len = HOLD_CYCLES;
        repeat (40) begin
          file_bytes.delete();
          repeat ($urandom_range(1, 2)) file_bytes.push_back(8'($urandom));
          post_file(0);
        end
      end
      repeat (4) queue_random_file();
      drain();
      phase_no++;
    end
    calm = 1'b0;

    if (pending_verdicts.size() != 0) begin
      errors++;
      $display("%0t: %0d verdicts never arrived", $time, pending_verdicts.size());
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
